FILE: rtl/hpti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hpti_pkg;

  localparam int GroupCountDefault = 1024;
  localparam int SlotsPerGroup     = 8;
  localparam int SlotBits          = 3;

  localparam int HashW  = 19;
  localparam int SegW   = 24;
  localparam int TagW   = 32;
  localparam int DataW  = 32;
  localparam int CountW = 14;

  localparam logic [SegW-1:0]   SegBaseReset = 24'h0D0C00;
  localparam logic [TagW-1:0]   TagSecondary = 32'h0000_0040;
  localparam logic [DataW-1:0]  PageMask     = 32'hFFFF_F000;
  // Referenced, changed and read/write page protection.
  localparam logic [DataW-1:0]  DataFlags    = 32'h0000_0182;
  localparam logic [CountW-1:0] CountMax     = 14'h3FFF;

  typedef enum logic [1:0] {
    STATUS_REFRESH = 2'd0,
    STATUS_INSERT  = 2'd1,
    STATUS_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic tag_we;
    logic data_we;
  } tbl_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/hpti_mod_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Remainder of the hash by the group count through a reciprocal multiplication.
// The quotient estimate is exact for every hash value, so one multiply and one
// subtract give the remainder, with value, quotient and remainder registered.
module hpti_mod_unit #(
  parameter int GROUP_COUNT = hpti_pkg::GroupCountDefault
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic [hpti_pkg::HashW-1:0]          value,
  output logic                                     done,
  output logic [$clog2(GROUP_COUNT)-1:0]           rem
);

  localparam int GW     = $clog2(GROUP_COUNT);
  localparam int RecipW = hpti_pkg::HashW + 1;
  localparam int Shift  = hpti_pkg::HashW + GW;
  localparam logic [63:0] RecipWide =
    ((64'd1 << Shift) + 64'(GROUP_COUNT) - 64'd1) / 64'(GROUP_COUNT);
  localparam logic [RecipW-1:0]          Recip   = RecipW'(RecipWide);
  localparam logic [hpti_pkg::HashW-1:0] Divisor = hpti_pkg::HashW'(GROUP_COUNT);

  logic [hpti_pkg::HashW-1:0]        value_r;
  logic [hpti_pkg::HashW-1:0]        quot;
  logic                              mul_step;
  logic                              sub_step;
  logic [hpti_pkg::HashW+RecipW-1:0] prod;
  logic [hpti_pkg::HashW-1:0]        quot_g;

  assign prod   = value_r * Recip;
  assign quot_g = hpti_pkg::HashW'(quot * Divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_step <= 1'b0;
      sub_step <= 1'b0;
      done     <= 1'b0;
    end else begin
      mul_step <= start;
      sub_step <= mul_step;
      done     <= sub_step;
      if (start) begin
        value_r <= value;
      end
      if (mul_step) begin
        quot <= hpti_pkg::HashW'(prod >> Shift);
      end
      if (sub_step) begin
        rem <= GW'(value_r - quot_g);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hpti_table.sv
`timescale 1ns / 1ps
`default_nettype none

module hpti_table #(
  parameter int GROUP_COUNT = hpti_pkg::GroupCountDefault
) (
  input  wire logic                                       clk,
  input  wire hpti_pkg::tbl_ctl_t                         ctl,
  input  wire logic [$clog2(GROUP_COUNT)+2:0]             wr_addr,
  input  wire logic [hpti_pkg::TagW-1:0]                  tag_wdata,
  input  wire logic [hpti_pkg::DataW-1:0]                 data_wdata,
  input  wire logic [$clog2(GROUP_COUNT)+2:0]             rd_addr,
  output logic [hpti_pkg::TagW-1:0]                       rd_tag
);

  localparam int Depth = GROUP_COUNT * hpti_pkg::SlotsPerGroup;

  logic [hpti_pkg::TagW-1:0]  tag_mem  [Depth];
  logic [hpti_pkg::DataW-1:0] data_mem [Depth];

  always_ff @(posedge clk) begin
    if (ctl.tag_we) begin
      tag_mem[wr_addr] <= tag_wdata;
    end
    rd_tag <= tag_mem[rd_addr];
  end

  // The data words are kept for the page walker; this block never reads them back.
  always_ff @(posedge clk) begin
    if (ctl.data_we) begin
      data_mem[wr_addr] <= data_wdata;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hashed_page_table_insert_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Inserts 4 KB page mappings into a hashed page table of GROUP_COUNT groups of eight
// entries, each a 32-bit tag and a 32-bit data word. After reset the table is cleared
// one entry per cycle; no request is accepted during that pass, while writes to the
// segment base register are taken at any time. One request is handled at a time: it is
// accepted, the remainder unit reduces the hash to a group index by a reciprocal
// multiplication, the slots (up to sixteen) are probed in turn through the single read
// port of the tag memory, and a final step writes the table, unless both groups are
// full, and the result register. A request that hits an existing entry early finishes
// sooner, and a result that has not been taken holds the next request in its last
// step. The result register lets the next request be accepted while a result still
// waits to be taken.
module hashed_page_table_insert_unit #(
  parameter int GROUP_COUNT = hpti_pkg::GroupCountDefault
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write_enable,
  input  wire logic [hpti_pkg::SegW-1:0]           cfg_write_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [31:0]                         effective_address,
  input  wire logic [31:0]                         physical_address,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [1:0]                               status,
  output logic                                     used_secondary,
  output logic [9:0]                               group_index,
  output logic [2:0]                               slot_index,
  output logic [hpti_pkg::CountW-1:0]              entries_inserted
);

  localparam int GW    = $clog2(GROUP_COUNT);
  localparam int AW    = GW + hpti_pkg::SlotBits;
  localparam int Depth = GROUP_COUNT * hpti_pkg::SlotsPerGroup;
  localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);
  localparam logic [GW:0]   GroupCnt = (GW + 1)'(GROUP_COUNT);
  // Remainder of the all-ones 32-bit word; the secondary group is this minus the primary, modulo the group count.
  localparam logic [GW:0]   MaxRem   = (GW + 1)'(64'hFFFF_FFFF % 64'(GROUP_COUNT));

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_HASH  = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t                        state;
  logic [hpti_pkg::SegW-1:0]     seg_base;
  logic [AW-1:0]                 clear_addr;
  logic [hpti_pkg::TagW-1:0]     want_tag;
  logic [hpti_pkg::DataW-1:0]    data_word;
  logic [GW-1:0]                 prim_group;
  logic [GW-1:0]                 sec_group;
  logic [4:0]                    issue_idx;
  logic                          chk_valid;
  logic [3:0]                    chk_idx;
  logic                          free_found;
  logic [3:0]                    free_idx;
  hpti_pkg::status_t             res_status;
  logic [3:0]                    res_idx;
  logic [hpti_pkg::CountW-1:0]   insert_count;
  logic [hpti_pkg::CountW-1:0]   insert_count_next;

  logic                          accept;
  logic [hpti_pkg::SegW-1:0]     segid_c;
  logic [hpti_pkg::HashW-1:0]    hash_c;
  logic                          mod_done;
  logic [GW-1:0]                 mod_rem;
  logic [GW:0]                   sec_wide;
  logic [hpti_pkg::TagW-1:0]     want_chk;
  logic                          hit;
  logic                          free_now;
  logic                          out_free;
  logic [GW-1:0]                 rd_group;
  logic [GW-1:0]                 res_group;
  logic [AW-1:0]                 rd_addr;
  logic [AW-1:0]                 wr_addr;
  logic [hpti_pkg::TagW-1:0]     tag_wdata;
  logic [hpti_pkg::DataW-1:0]    data_wdata;
  logic [hpti_pkg::TagW-1:0]     rd_tag;
  hpti_pkg::tbl_ctl_t            tbl_ctl;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign segid_c = seg_base + hpti_pkg::SegW'(effective_address[31:28]);
  assign hash_c  = segid_c[hpti_pkg::HashW-1:0] ^ {3'b000, effective_address[27:12]};

  hpti_mod_unit #(
    .GROUP_COUNT(GROUP_COUNT)
  ) u_mod (
    .clk  (clk),
    .rst  (rst),
    .start(accept),
    .value(hash_c),
    .done (mod_done),
    .rem  (mod_rem)
  );

  assign sec_wide = MaxRem + ((MaxRem >= {1'b0, mod_rem}) ? '0 : GroupCnt) - {1'b0, mod_rem};

  assign want_chk = want_tag | (chk_idx[3] ? hpti_pkg::TagSecondary : '0);
  assign hit      = chk_valid && (rd_tag == want_chk);
  assign free_now = chk_valid && !rd_tag[hpti_pkg::TagW-1];

  assign rd_group  = issue_idx[3] ? sec_group : prim_group;
  assign rd_addr   = {rd_group, issue_idx[2:0]};
  assign res_group = res_idx[3] ? sec_group : prim_group;

  always_comb begin
    tbl_ctl    = '0;
    wr_addr    = {res_group, res_idx[2:0]};
    tag_wdata  = want_tag | (res_idx[3] ? hpti_pkg::TagSecondary : '0);
    data_wdata = data_word;
    if (state == ST_CLEAR) begin
      tbl_ctl.tag_we  = 1'b1;
      tbl_ctl.data_we = 1'b1;
      wr_addr         = clear_addr;
      tag_wdata       = '0;
      data_wdata      = '0;
    end else if (state == ST_DONE && out_free) begin
      tbl_ctl.data_we = (res_status == hpti_pkg::STATUS_REFRESH) ||
                        (res_status == hpti_pkg::STATUS_INSERT);
      tbl_ctl.tag_we  = (res_status == hpti_pkg::STATUS_INSERT);
    end
  end

  always_comb begin
    insert_count_next = insert_count;
    if (res_status == hpti_pkg::STATUS_INSERT && insert_count != hpti_pkg::CountMax) begin
      insert_count_next = insert_count + 1'b1;
    end
  end

  hpti_table #(
    .GROUP_COUNT(GROUP_COUNT)
  ) u_table (
    .clk       (clk),
    .ctl       (tbl_ctl),
    .wr_addr   (wr_addr),
    .tag_wdata (tag_wdata),
    .data_wdata(data_wdata),
    .rd_addr   (rd_addr),
    .rd_tag    (rd_tag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_base <= hpti_pkg::SegBaseReset;
    end else if (cfg_write_enable) begin
      seg_base <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clear_addr   <= '0;
      chk_valid    <= 1'b0;
      out_valid    <= 1'b0;
      insert_count <= '0;
    end else begin
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
          if (clear_addr == LastAddr) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            want_tag  <= {1'b1, segid_c, 1'b0, effective_address[27:22]};
            data_word <= (physical_address & hpti_pkg::PageMask) | hpti_pkg::DataFlags;
            state     <= ST_HASH;
          end
        end
        ST_HASH: begin
          if (mod_done) begin
            prim_group <= mod_rem;
            sec_group  <= sec_wide[GW-1:0];
            issue_idx  <= '0;
            chk_valid  <= 1'b0;
            free_found <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Reads are issued one slot ahead of the compare; a refresh hit anywhere
          // wins over an earlier free slot, so the first free slot is only noted.
          if (!issue_idx[4]) begin
            issue_idx <= issue_idx + 1'b1;
          end
          chk_valid <= !issue_idx[4];
          chk_idx   <= issue_idx[3:0];
          if (free_now && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= chk_idx;
          end
          if (hit) begin
            res_status <= hpti_pkg::STATUS_REFRESH;
            res_idx    <= chk_idx;
            state      <= ST_DONE;
          end else if (chk_valid && chk_idx == 4'hF) begin
            if (free_found) begin
              res_status <= hpti_pkg::STATUS_INSERT;
              res_idx    <= free_idx;
            end else if (free_now) begin
              res_status <= hpti_pkg::STATUS_INSERT;
              res_idx    <= chk_idx;
            end else begin
              res_status <= hpti_pkg::STATUS_FULL;
              res_idx    <= '0;
            end
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            status           <= res_status;
            used_secondary   <= res_idx[3];
            group_index      <= 10'(res_group);
            slot_index       <= res_idx[2:0];
            entries_inserted <= insert_count_next;
            insert_count     <= insert_count_next;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The table is written only by the clearing pass or at the end of a request.
  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    (tbl_ctl.tag_we || tbl_ctl.data_we) |-> (state == ST_CLEAR || state == ST_DONE))
    else $error("table written outside clear or completion");

  // A result is loaded only when the register is free, so none is overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (state != ST_IDLE || $past(state) != ST_DONE))
    else $error("result register overwritten");

  // The remainder unit finishes only while a request waits for its group index.
  a_mod_phase: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == ST_HASH))
    else $error("remainder done outside hash phase");

  // The insert count never goes down.
  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (insert_count >= $past(insert_count)))
    else $error("insert count decreased");

  // After a request is accepted no other is taken until its result is loaded.
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("second request accepted while busy");

endmodule

`default_nettype wire
